// File: hw/rtl/htx4_pkg.sv
// htx4_pkg: shared types and constants for the 4x4 homogeneous transform.
// No dependencies; used by htx4_lane, htx4_merge and homogeneous_transform_4x4.
`default_nettype none

package htx4_pkg;

  localparam int unsigned NUM_LANES = 4;
  localparam int unsigned ELEM_W    = 32;
  localparam int unsigned REG_W     = 64;
  localparam int unsigned NUM_REGS  = 8;
  localparam int unsigned REG_IDX_W = 3;

  // Full-width products and the growth of the adder tree.
  localparam int unsigned PROD_W = 64;
  localparam int unsigned PAIR_W = 65;
  localparam int unsigned SUM_W  = 66;

  localparam logic [ELEM_W-1:0] SAT_MAX = 32'h7fff_ffff;
  localparam logic [ELEM_W-1:0] SAT_MIN = 32'h8000_0000;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_ROW0_COLS01,
    REG_ROW0_COLS23,
    REG_ROW1_COLS01,
    REG_ROW1_COLS23,
    REG_ROW2_COLS01,
    REG_ROW2_COLS23,
    REG_ROW3_COLS01,
    REG_ROW3_COLS23
  } htx4_reg_e;

  // Per-stage load enables, shared by all lanes.
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } htx4_adv_t;

  typedef logic [NUM_LANES-1:0][ELEM_W-1:0] htx4_vec_t;

endpackage : htx4_pkg

`default_nettype wire

// File: hw/rtl/htx4_lane.sv
// htx4_lane: one matrix row; four multipliers, a registered adder tree,
// then floor shift and saturation. Depends on htx4_pkg.
`default_nettype none

module htx4_lane #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic                                clk_i,
  input  wire htx4_pkg::htx4_adv_t                 adv_i,
  input  wire htx4_pkg::htx4_vec_t                 coef_i,
  input  wire htx4_pkg::htx4_vec_t                 vec_i,
  output logic [htx4_pkg::ELEM_W-1:0]              res_o,
  output logic                                     sat_o
);

  logic signed [htx4_pkg::PROD_W-1:0] prod_d [htx4_pkg::NUM_LANES];
  logic signed [htx4_pkg::PROD_W-1:0] prod_q [htx4_pkg::NUM_LANES];
  logic signed [htx4_pkg::PAIR_W-1:0] pair_d [2];
  logic signed [htx4_pkg::PAIR_W-1:0] pair_q [2];
  logic signed [htx4_pkg::SUM_W-1:0]  sum_d;
  logic signed [htx4_pkg::SUM_W-1:0]  sum_q;
  logic signed [htx4_pkg::SUM_W-1:0]  shr;
  logic                               ovf;

  // stage 1: 32x32 signed products
  always_comb begin
    for (int k = 0; k < htx4_pkg::NUM_LANES; k++) begin
      prod_d[k] = $signed(coef_i[k]) * $signed(vec_i[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i.s1) begin
      prod_q <= prod_d;
    end
  end

  // stage 2: pair sums
  assign pair_d[0] = htx4_pkg::PAIR_W'(prod_q[0]) + htx4_pkg::PAIR_W'(prod_q[1]);
  assign pair_d[1] = htx4_pkg::PAIR_W'(prod_q[2]) + htx4_pkg::PAIR_W'(prod_q[3]);

  always_ff @(posedge clk_i) begin
    if (adv_i.s2) begin
      pair_q <= pair_d;
    end
  end

  // stage 3: exact row sum
  assign sum_d = htx4_pkg::SUM_W'(pair_q[0]) + htx4_pkg::SUM_W'(pair_q[1]);

  always_ff @(posedge clk_i) begin
    if (adv_i.s3) begin
      sum_q <= sum_d;
    end
  end

  // arithmetic shift floors; overflow when bits above 31 disagree with sign
  assign shr = sum_q >>> FRAC_BITS;
  assign ovf = !((&shr[htx4_pkg::SUM_W-1:htx4_pkg::ELEM_W-1]) ||
                 (~|shr[htx4_pkg::SUM_W-1:htx4_pkg::ELEM_W-1]));

  always_comb begin
    if (!ovf) begin
      res_o = shr[htx4_pkg::ELEM_W-1:0];
    end else if (shr[htx4_pkg::SUM_W-1]) begin
      res_o = htx4_pkg::SAT_MIN;
    end else begin
      res_o = htx4_pkg::SAT_MAX;
    end
  end

  assign sat_o = ovf;

endmodule : htx4_lane

`default_nettype wire

// File: hw/rtl/htx4_merge.sv
// htx4_merge: output register; gathers the four lane results and folds
// their clip flags into one. Depends on htx4_pkg.
`default_nettype none

module htx4_merge (
  input  wire logic                               clk_i,
  input  wire logic                               en_i,
  input  wire htx4_pkg::htx4_vec_t                lane_res_i,
  input  wire logic [htx4_pkg::NUM_LANES-1:0]     lane_sat_i,
  output htx4_pkg::htx4_vec_t                     out_vec_o,
  output logic                                    out_sat_o
);

  htx4_pkg::htx4_vec_t out_vec_q;
  logic                out_sat_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      out_vec_q <= lane_res_i;
      out_sat_q <= |lane_sat_i;
    end
  end

  assign out_vec_o = out_vec_q;
  assign out_sat_o = out_sat_q;

endmodule : htx4_merge

`default_nettype wire

// File: hw/rtl/homogeneous_transform_4x4.sv
// homogeneous_transform_4x4: top level; coefficient registers, pipeline
// control, four row lanes and the output merge. Depends on htx4_pkg,
// htx4_lane and htx4_merge.
//
//   channel  | handshake                 | payload
//   ---------+---------------------------+----------------------------------
//   input    | in_valid_i / in_stall_o   | in_x_i, in_y_i, in_z_i, in_w_i
//   output   | out_valid_o / out_stall_i | out_x_o .. out_w_o, out_saturated_o
//   config   | cfg_we_i                  | cfg_index_i, cfg_wdata_i
//
// One item per cycle sustained while out_stall_i is low. Four register stages:
// multiply, pair add, row add, and shift/saturate into the output register.
// out_valid_o rises once an accepted item reaches the output register.
// The datapath holds 16 parallel 32x32 multipliers and 66-bit row adders.
// rst_ni clears the valid bits and loads the identity matrix.
// Each stage loads when it is empty or its successor moves, so bubbles
// collapse while the output is stalled; in_stall_o rises only when all
// four stages hold items.
`default_nettype none

module homogeneous_transform_4x4 #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // configuration
  input  wire logic                              cfg_we_i,
  input  wire logic [htx4_pkg::REG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [htx4_pkg::REG_W-1:0]        cfg_wdata_i,
  // input items
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic signed [htx4_pkg::ELEM_W-1:0] in_x_i,
  input  wire logic signed [htx4_pkg::ELEM_W-1:0] in_y_i,
  input  wire logic signed [htx4_pkg::ELEM_W-1:0] in_z_i,
  input  wire logic signed [htx4_pkg::ELEM_W-1:0] in_w_i,
  // result items
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic signed [htx4_pkg::ELEM_W-1:0]     out_x_o,
  output logic signed [htx4_pkg::ELEM_W-1:0]     out_y_o,
  output logic signed [htx4_pkg::ELEM_W-1:0]     out_z_o,
  output logic signed [htx4_pkg::ELEM_W-1:0]     out_w_o,
  output logic                                   out_saturated_o
);

  // 1.0 in the configured fixed-point format
  localparam logic [htx4_pkg::REG_W-1:0] ONE_LO = htx4_pkg::REG_W'(1) << FRAC_BITS;
  localparam logic [htx4_pkg::REG_W-1:0] ONE_HI = ONE_LO << htx4_pkg::ELEM_W;

  logic [htx4_pkg::REG_W-1:0] cfg_q [htx4_pkg::NUM_REGS];

  logic v1_q, v1_d, v2_q, v2_d, v3_q, v3_d, vo_q, vo_d;
  logic rdy1, rdy2, rdy3, rdy_o;

  htx4_pkg::htx4_adv_t                  adv;
  htx4_pkg::htx4_vec_t                  vec_in;
  htx4_pkg::htx4_vec_t                  lane_res;
  logic [htx4_pkg::NUM_LANES-1:0]       lane_sat;
  htx4_pkg::htx4_vec_t                  out_vec;
  logic                                 out_sat;

  // ---------------------------------------------------------------------
  // coefficient registers, identity after reset
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q[htx4_pkg::REG_ROW0_COLS01] <= ONE_LO;
      cfg_q[htx4_pkg::REG_ROW0_COLS23] <= '0;
      cfg_q[htx4_pkg::REG_ROW1_COLS01] <= ONE_HI;
      cfg_q[htx4_pkg::REG_ROW1_COLS23] <= '0;
      cfg_q[htx4_pkg::REG_ROW2_COLS01] <= '0;
      cfg_q[htx4_pkg::REG_ROW2_COLS23] <= ONE_LO;
      cfg_q[htx4_pkg::REG_ROW3_COLS01] <= '0;
      cfg_q[htx4_pkg::REG_ROW3_COLS23] <= ONE_HI;
    end else if (cfg_we_i) begin
      cfg_q[cfg_index_i] <= cfg_wdata_i;
    end
  end

  // ---------------------------------------------------------------------
  // pipeline control: a stage loads when empty or when its successor moves
  // ---------------------------------------------------------------------
  assign rdy_o = !vo_q || !out_stall_i;
  assign rdy3  = !v3_q || rdy_o;
  assign rdy2  = !v2_q || rdy3;
  assign rdy1  = !v1_q || rdy2;

  assign v1_d = rdy1  ? in_valid_i : v1_q;
  assign v2_d = rdy2  ? v1_q       : v2_q;
  assign v3_d = rdy3  ? v2_q       : v3_q;
  assign vo_d = rdy_o ? v3_q       : vo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      v1_q <= v1_d;
      v2_q <= v2_d;
      v3_q <= v3_d;
      vo_q <= vo_d;
    end
  end

  assign adv.s1 = rdy1;
  assign adv.s2 = rdy2;
  assign adv.s3 = rdy3;

  assign in_stall_o = !rdy1;

  // ---------------------------------------------------------------------
  // row lanes
  // ---------------------------------------------------------------------
  assign vec_in = {in_w_i, in_z_i, in_y_i, in_x_i};

  for (genvar r = 0; r < htx4_pkg::NUM_LANES; r++) begin : g_lane
    htx4_pkg::htx4_vec_t coef;
    // column 0 in the low half of cols01, column 3 in the high half of cols23
    assign coef = {cfg_q[2*r+1], cfg_q[2*r]};

    htx4_lane #(
      .FRAC_BITS(FRAC_BITS)
    ) u_lane (
      .clk_i (clk_i),
      .adv_i (adv),
      .coef_i(coef),
      .vec_i (vec_in),
      .res_o (lane_res[r]),
      .sat_o (lane_sat[r])
    );
  end

  // ---------------------------------------------------------------------
  // merge into the output register
  // ---------------------------------------------------------------------
  htx4_merge u_merge (
    .clk_i     (clk_i),
    .en_i      (rdy_o),
    .lane_res_i(lane_res),
    .lane_sat_i(lane_sat),
    .out_vec_o (out_vec),
    .out_sat_o (out_sat)
  );

  assign out_valid_o     = vo_q;
  assign out_x_o         = out_vec[0];
  assign out_y_o         = out_vec[1];
  assign out_z_o         = out_vec[2];
  assign out_w_o         = out_vec[3];
  assign out_saturated_o = out_sat;

`ifndef SYNTHESIS
  // input is held off only with every stage occupied
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (v1_q && v2_q && v3_q && vo_q && out_stall_i))
    else $error("input stalled with a free pipeline stage");

  // an accepted item lands in stage 1
  a_accept_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> v1_q)
    else $error("accepted item lost at stage 1");

  // last lane stage moving forward produces a result
  a_s3_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v3_q && rdy_o) |=> out_valid_o)
    else $error("item lost between row sum and output");

  // a clip flag implies at least one component sits at a rail
  a_sat_rail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_saturated_o) |->
      (out_x_o == htx4_pkg::SAT_MAX || out_x_o == htx4_pkg::SAT_MIN ||
       out_y_o == htx4_pkg::SAT_MAX || out_y_o == htx4_pkg::SAT_MIN ||
       out_z_o == htx4_pkg::SAT_MAX || out_z_o == htx4_pkg::SAT_MIN ||
       out_w_o == htx4_pkg::SAT_MAX || out_w_o == htx4_pkg::SAT_MIN))
    else $error("saturated flag without a clipped component");
`endif

endmodule : homogeneous_transform_4x4

`default_nettype wire

// File: tb/htx4_xform_checker.sv
`timescale 1ns / 1ps
// htx4_xform_checker: watches the config, input and result channels of the
// 4x4 transform, predicts every result and compares it field by field.
// Depends on htx4_pkg only.
module htx4_xform_checker #(
  parameter int unsigned FRAC_BITS   = 16,
  parameter int unsigned MAX_REPORTS = 10
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [htx4_pkg::REG_IDX_W-1:0]   cfg_index_i,
  input  logic [htx4_pkg::REG_W-1:0]       cfg_wdata_i,
  input  logic                             in_valid_i,
  input  logic                             in_stall_i,
  input  logic [htx4_pkg::ELEM_W-1:0]      in_x_i,
  input  logic [htx4_pkg::ELEM_W-1:0]      in_y_i,
  input  logic [htx4_pkg::ELEM_W-1:0]      in_z_i,
  input  logic [htx4_pkg::ELEM_W-1:0]      in_w_i,
  input  logic                             out_valid_i,
  input  logic                             out_stall_i,
  input  logic [htx4_pkg::ELEM_W-1:0]      out_x_i,
  input  logic [htx4_pkg::ELEM_W-1:0]      out_y_i,
  input  logic [htx4_pkg::ELEM_W-1:0]      out_z_i,
  input  logic [htx4_pkg::ELEM_W-1:0]      out_w_i,
  input  logic                             out_saturated_i,
  output int                               fail_count_o,
  output int                               pending_o,
  output int                               items_o,
  output int                               saturated_o,
  output int                               in_stall_cycles_o
);

  localparam longint ELEM_HI = 64'sd2147483647;
  localparam longint ELEM_LO = -64'sd2147483648;

  // [row][col], same layout the registers load
  typedef logic [htx4_pkg::NUM_LANES-1:0][htx4_pkg::NUM_LANES-1:0][htx4_pkg::ELEM_W-1:0]
    coeff_mat_t;

  typedef struct packed {
    htx4_pkg::htx4_vec_t comp;   // comp[0] = x .. comp[3] = w
    logic                sat;
  } xform_t;

  coeff_mat_t coeff;
  xform_t     expected_vecs[$];
  int         fails, items, sat_items, stall_cycles;

  assign fail_count_o      = fails;
  assign pending_o         = expected_vecs.size();
  assign items_o           = items;
  assign saturated_o       = sat_items;
  assign in_stall_cycles_o = stall_cycles;

  function automatic coeff_mat_t identity_coeffs();
    coeff_mat_t m;
    m = '0;
    for (int k = 0; k < htx4_pkg::NUM_LANES; k++)
      m[k][k] = htx4_pkg::ELEM_W'(1 << FRAC_BITS);
    return m;
  endfunction

  // exact 66-bit row sums, floor shift, clip to 32 bits
  function automatic xform_t apply_matrix(input coeff_mat_t m,
                                          input htx4_pkg::htx4_vec_t v);
    xform_t                            r;
    logic signed [htx4_pkg::SUM_W-1:0] acc;
    logic signed [htx4_pkg::SUM_W-1:0] scaled;
    longint                            prod;
    r = '0;
    for (int row = 0; row < htx4_pkg::NUM_LANES; row++) begin
      acc = '0;
      for (int col = 0; col < htx4_pkg::NUM_LANES; col++) begin
        prod = longint'($signed(m[row][col])) * longint'($signed(v[col]));
        acc  = acc + {{(htx4_pkg::SUM_W-htx4_pkg::PROD_W){prod[htx4_pkg::PROD_W-1]}},
                      prod};
      end
      scaled = acc >>> FRAC_BITS;
      if (scaled > ELEM_HI) begin
        r.comp[row] = htx4_pkg::SAT_MAX;
        r.sat       = 1'b1;
      end else if (scaled < ELEM_LO) begin
        r.comp[row] = htx4_pkg::SAT_MIN;
        r.sat       = 1'b1;
      end else begin
        r.comp[row] = scaled[htx4_pkg::ELEM_W-1:0];
      end
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    xform_t want;
    xform_t got;
    logic   bad;
    if (!rst_ni) begin
      coeff <= identity_coeffs();
      expected_vecs.delete();
      fails        = 0;
      items        = 0;
      sat_items    = 0;
      stall_cycles = 0;
    end else begin
      if (cfg_we_i) begin
        case (htx4_pkg::htx4_reg_e'(cfg_index_i))
          htx4_pkg::REG_ROW0_COLS01: coeff[0][1:0] <= cfg_wdata_i;
          htx4_pkg::REG_ROW0_COLS23: coeff[0][3:2] <= cfg_wdata_i;
          htx4_pkg::REG_ROW1_COLS01: coeff[1][1:0] <= cfg_wdata_i;
          htx4_pkg::REG_ROW1_COLS23: coeff[1][3:2] <= cfg_wdata_i;
          htx4_pkg::REG_ROW2_COLS01: coeff[2][1:0] <= cfg_wdata_i;
          htx4_pkg::REG_ROW2_COLS23: coeff[2][3:2] <= cfg_wdata_i;
          htx4_pkg::REG_ROW3_COLS01: coeff[3][1:0] <= cfg_wdata_i;
          htx4_pkg::REG_ROW3_COLS23: coeff[3][3:2] <= cfg_wdata_i;
          default: ;
        endcase
      end

      if (in_valid_i && in_stall_i) stall_cycles++;

      if (in_valid_i && !in_stall_i) begin
        want = apply_matrix(coeff, {in_w_i, in_z_i, in_y_i, in_x_i});
        expected_vecs.push_back(want);
        items++;
        if (want.sat) sat_items++;
      end

      if (out_valid_i && !out_stall_i) begin
        got.comp = {out_w_i, out_z_i, out_y_i, out_x_i};
        got.sat  = out_saturated_i;
        if (expected_vecs.size() == 0) begin
          fails++;
          if (fails <= MAX_REPORTS)
            $display("%0t: result with nothing pending: x=%h y=%h z=%h w=%h sat=%b",
                     $time, got.comp[0], got.comp[1], got.comp[2], got.comp[3], got.sat);
        end else begin
          want = expected_vecs.pop_front();
          bad  = (got.sat !== want.sat);
          for (int k = 0; k < htx4_pkg::NUM_LANES; k++)
            if (got.comp[k] !== want.comp[k]) bad = 1'b1;
          if (bad) begin
            fails++;
            if (fails <= MAX_REPORTS) begin
              $display("%0t: mismatch, expected x=%h y=%h z=%h w=%h sat=%b", $time,
                       want.comp[0], want.comp[1], want.comp[2], want.comp[3], want.sat);
              $display("%0t:           actual   x=%h y=%h z=%h w=%h sat=%b", $time,
                       got.comp[0], got.comp[1], got.comp[2], got.comp[3], got.sat);
            end
          end
        end
      end
    end
  end

endmodule

// File: tb/homogeneous_transform_4x4_tb.sv
`timescale 1ns / 1ps
// homogeneous_transform_4x4_tb: clock, reset, coefficient loads, vector
// stimulus and output backpressure; htx4_xform_checker does the predicting.
// Depends on htx4_pkg, homogeneous_transform_4x4 and htx4_xform_checker.
module homogeneous_transform_4x4_tb;

  localparam int unsigned FRAC_BITS       = 16;
  localparam int unsigned PHASES          = 10;
  localparam int unsigned ITEMS_PER_PHASE = 50;
  localparam int unsigned PRESSURE_PHASE  = 3;
  localparam int unsigned HOLD_CYCLES     = 48;
  localparam int unsigned IDLE_PCT        = 15;
  localparam int unsigned DRAIN_CYCLES    = 8;    // a bit over the pipeline latency

  localparam logic [htx4_pkg::ELEM_W-1:0] V_MAX    = 32'h7fff_ffff;
  localparam logic [htx4_pkg::ELEM_W-1:0] V_MIN    = 32'h8000_0000;
  localparam logic [htx4_pkg::ELEM_W-1:0] V_NEG1   = 32'hffff_ffff;
  localparam logic [htx4_pkg::ELEM_W-1:0] UNIT     = htx4_pkg::ELEM_W'(1 << FRAC_BITS);
  localparam logic [htx4_pkg::ELEM_W-1:0] NEG_UNIT = htx4_pkg::ELEM_W'(-(1 << FRAC_BITS));

  // [row][col]
  typedef logic [htx4_pkg::NUM_LANES-1:0][htx4_pkg::NUM_LANES-1:0][htx4_pkg::ELEM_W-1:0]
    coeff_mat_t;

  logic                               clk       = 1'b0;
  logic                               rst_n     = 1'b0;
  logic                               cfg_we    = 1'b0;
  htx4_pkg::htx4_reg_e                cfg_index = htx4_pkg::REG_ROW0_COLS01;
  logic [htx4_pkg::REG_W-1:0]         cfg_wdata = '0;
  logic                               in_valid  = 1'b0;
  logic                               in_stall;
  logic signed [htx4_pkg::ELEM_W-1:0] in_x      = '0;
  logic signed [htx4_pkg::ELEM_W-1:0] in_y      = '0;
  logic signed [htx4_pkg::ELEM_W-1:0] in_z      = '0;
  logic signed [htx4_pkg::ELEM_W-1:0] in_w      = '0;
  logic                               out_valid;
  logic                               out_stall = 1'b0;
  logic signed [htx4_pkg::ELEM_W-1:0] out_x, out_y, out_z, out_w;
  logic                               out_saturated;

  // random idling of each side, and the long receiver hold-off
  logic        send_idle = 1'b0;
  logic        recv_idle = 1'b0;
  logic        hold_req  = 1'b0;
  logic        hold_ack  = 1'b0;
  int unsigned hold_left = 0;

  int fail_count, pending, items_seen, sat_seen, stall_cycles;
  int settings_loaded = 1;   // the identity matrix from reset counts as one

  homogeneous_transform_4x4 #(.FRAC_BITS(FRAC_BITS)) uut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_index_i    (cfg_index),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .in_x_i         (in_x),
    .in_y_i         (in_y),
    .in_z_i         (in_z),
    .in_w_i         (in_w),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .out_x_o        (out_x),
    .out_y_o        (out_y),
    .out_z_o        (out_z),
    .out_w_o        (out_w),
    .out_saturated_o(out_saturated)
  );

  htx4_xform_checker #(.FRAC_BITS(FRAC_BITS)) u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_index_i      (cfg_index),
    .cfg_wdata_i      (cfg_wdata),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .in_x_i           (in_x),
    .in_y_i           (in_y),
    .in_z_i           (in_z),
    .in_w_i           (in_w),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .out_x_i          (out_x),
    .out_y_i          (out_y),
    .out_z_i          (out_z),
    .out_w_i          (out_w),
    .out_saturated_i  (out_saturated),
    .fail_count_o     (fail_count),
    .pending_o        (pending),
    .items_o          (items_seen),
    .saturated_o      (sat_seen),
    .in_stall_cycles_o(stall_cycles)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result side. A toggle of hold_req starts a long hold-off counted here;
  // otherwise the stall is random while recv_idle is set.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_req != hold_ack) begin
      hold_ack  <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= recv_idle && ($urandom_range(99) < IDLE_PCT);
    end
  end

  // Mostly small values so rows stay in range, some full-range ones that
  // tend to saturate, and a few corner values.
  function automatic logic [htx4_pkg::ELEM_W-1:0] pick_elem(input int unsigned span_bits);
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 20) return $urandom();
    if (roll < 85)
      return htx4_pkg::ELEM_W'($urandom_range((1 << (span_bits + 1)) - 1) -
                               (1 << span_bits));
    case ($urandom_range(6))
      0:       return V_MIN;
      1:       return V_MAX;
      2:       return '0;
      3:       return V_NEG1;
      4:       return htx4_pkg::ELEM_W'(1);
      5:       return UNIT;
      default: return NEG_UNIT;
    endcase
  endfunction

  function automatic coeff_mat_t identity_matrix();
    coeff_mat_t m;
    m = '0;
    for (int k = 0; k < htx4_pkg::NUM_LANES; k++) m[k][k] = UNIT;
    return m;
  endfunction

  function automatic coeff_mat_t uniform_matrix(input logic [htx4_pkg::ELEM_W-1:0] c);
    coeff_mat_t m;
    for (int r = 0; r < htx4_pkg::NUM_LANES; r++)
      for (int k = 0; k < htx4_pkg::NUM_LANES; k++) m[r][k] = c;
    return m;
  endfunction

  function automatic coeff_mat_t random_matrix(input int unsigned full_pct);
    coeff_mat_t m;
    for (int r = 0; r < htx4_pkg::NUM_LANES; r++)
      for (int k = 0; k < htx4_pkg::NUM_LANES; k++)
        m[r][k] = ($urandom_range(99) < full_pct) ? $urandom() : pick_elem(17);
    return m;
  endfunction

  // Called right after a rising edge; leaves the caller on the next one.
  task automatic write_reg(input htx4_pkg::htx4_reg_e idx,
                           input logic [htx4_pkg::REG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  // Only while idle: nothing in flight, in_valid low.
  task automatic load_matrix(input coeff_mat_t m);
    @(posedge clk);
    write_reg(htx4_pkg::REG_ROW0_COLS01, m[0][1:0]);
    write_reg(htx4_pkg::REG_ROW0_COLS23, m[0][3:2]);
    write_reg(htx4_pkg::REG_ROW1_COLS01, m[1][1:0]);
    write_reg(htx4_pkg::REG_ROW1_COLS23, m[1][3:2]);
    write_reg(htx4_pkg::REG_ROW2_COLS01, m[2][1:0]);
    write_reg(htx4_pkg::REG_ROW2_COLS23, m[2][3:2]);
    write_reg(htx4_pkg::REG_ROW3_COLS01, m[3][1:0]);
    write_reg(htx4_pkg::REG_ROW3_COLS23, m[3][3:2]);
    cfg_we <= 1'b0;
    settings_loaded++;
  endtask

  // Valid stays up between back-to-back items; it only drops in a gap or at
  // the end of a burst, never in the same step it is raised.
  task automatic send_vec(input logic [htx4_pkg::ELEM_W-1:0] x, y, z, w);
    if (send_idle)
      while ($urandom_range(99) < IDLE_PCT) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    in_valid <= 1'b1;
    in_x     <= x;
    in_y     <= y;
    in_z     <= z;
    in_w     <= w;
    do @(posedge clk); while (in_stall);
  endtask

  // End a burst and wait for every outstanding result.
  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  initial begin
    coeff_mat_t m;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Identity from reset: vectors pass through untouched, extremes included.
    send_vec('0, '0, '0, '0);
    send_vec(V_MAX, V_MAX, V_MAX, V_MAX);
    send_vec(V_MIN, V_MIN, V_MIN, V_MIN);
    send_vec(V_NEG1, htx4_pkg::ELEM_W'(1), NEG_UNIT, UNIT);
    send_vec($urandom(), $urandom(), $urandom(), $urandom());
    drain();

    // Raw coefficient 1: -1 must floor to -1, +1 to 0.
    load_matrix(uniform_matrix(htx4_pkg::ELEM_W'(1)));
    send_vec(V_NEG1, '0, '0, '0);
    send_vec(htx4_pkg::ELEM_W'(1), '0, '0, '0);
    send_vec(V_MIN, V_MIN, V_MIN, V_MIN);
    send_vec(V_MAX, V_MAX, V_MAX, V_MAX);
    drain();

    // Most negative coefficients: largest products, clip both ways.
    load_matrix(uniform_matrix(V_MIN));
    send_vec(V_MIN, V_MIN, V_MIN, V_MIN);
    send_vec(V_MAX, V_MAX, V_MAX, V_MAX);
    send_vec('0, '0, '0, '0);
    send_vec(htx4_pkg::ELEM_W'(1), V_NEG1, '0, '0);
    drain();

    // Most positive coefficients.
    load_matrix(uniform_matrix(V_MAX));
    send_vec(V_MAX, V_MAX, V_MAX, V_MAX);
    send_vec(V_MIN, V_MAX, '0, '0);
    send_vec(UNIT, UNIT, UNIT, UNIT);
    drain();

    // Only row 0 overflows; the flag must still be raised.
    m    = identity_matrix();
    m[0] = {htx4_pkg::NUM_LANES{V_MAX}};
    load_matrix(m);
    send_vec(UNIT, UNIT, '0, '0);
    send_vec(NEG_UNIT, UNIT, UNIT, V_MIN);
    drain();

    // Random phases. Phase 0 runs flat out on both sides; the pressure
    // phase holds the output long enough that the pipeline fills and the
    // input stalls while the sender keeps offering items. Each phase ends
    // with the sender waiting for every result before the next load.
    for (int unsigned ph = 0; ph < PHASES; ph++) begin
      send_idle <= (ph != 0) && (ph != PRESSURE_PHASE);
      recv_idle <= (ph != 0);
      load_matrix(random_matrix((ph % 4) * 33));
      if (ph == PRESSURE_PHASE) hold_req <= ~hold_req;
      for (int unsigned k = 0; k < ITEMS_PER_PHASE; k++)
        send_vec(pick_elem(20), pick_elem(20), pick_elem(20), pick_elem(20));
      drain();
    end

    recv_idle <= 1'b0;
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d vectors under %0d coefficient settings;", items_seen,
             settings_loaded);
    $display("%0d of them clipped, input held off for %0d cycles.", sat_seen, stall_cycles);
    if (pending != 0) $display("%0d results never arrived", pending);
    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Far beyond the slowest correct run.
  initial begin
    #2_000_000;
    $display("timeout with %0d results outstanding", pending);
    $display("TEST FAILED");
    $finish;
  end

endmodule
